@@ design/bffa_pkg.sv @@
`timescale 1ns / 1ps

package bffa_pkg;

  // Field widths of the request and result ports.
  localparam int unsigned POS_W  = 12;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 13;

  // Default geometry of the usage bitmap.
  localparam int unsigned DEF_MAX_SLOTS = 4096;
  localparam int unsigned DEF_WORD_BITS = 32;

  // Slot count after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

endpackage

@@ design/bitmap_first_fit_allocator_top.sv @@
`timescale 1ns / 1ps

// Bitmap first-fit slot allocator. One request is taken when start is high and busy is low;
// its result appears on status_o, slot_o and allocated_o for exactly one cycle with done_o
// high, and the receiver cannot hold it off. Requests that need no bitmap access (an
// out-of-range free or test, and the unused mode) give their result in the cycle after start
// without raising busy. A free or test in range keeps busy high through S_DIV (slot index to
// word and bit) and S_RMW (one read-modify-write), which registers its result. An allocate
// scans one bitmap word per cycle through the single read port of the bitmap memory, at most
// WORD_COUNT words (128 with the defaults) with busy high, stopping at the first word with a
// free slot below the slot count or reporting full at the last word below it. The bitmap needs
// no clearing pass after reset: a valid bit per word makes an unwritten word read as all free.
module bitmap_first_fit_allocator_top #(
  parameter int unsigned MAX_SLOTS = bffa_pkg::DEF_MAX_SLOTS,
  parameter int unsigned WORD_BITS = bffa_pkg::DEF_WORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bffa_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [bffa_pkg::MODE_W-1:0] mode_i,
  input  logic [bffa_pkg::POS_W-1:0]  position_i,
  output logic                        done_o,
  output logic [bffa_pkg::STAT_W-1:0] status_o,
  output logic [bffa_pkg::POS_W-1:0]  slot_o,
  output logic                        allocated_o
);

  import bffa_pkg::*;

  localparam int unsigned WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned BIDX_W     = $clog2(WORD_BITS);
  localparam int unsigned BASE_W     = $clog2(WORD_COUNT * WORD_BITS + 1);

  // Reciprocal for the slot-to-word split: exact floor(pos / WORD_BITS) for any POS_W-bit pos.
  localparam int unsigned RSH_W   = POS_W + $clog2(WORD_BITS);
  localparam int unsigned RECIP_W = POS_W + 2;
  localparam int unsigned PROD_W  = POS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'(1) << RSH_W) + 64'(WORD_BITS) - 64'(1)) / 64'(WORD_BITS));

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RMW,
    S_SCAN
  } state_e;

  state_e                   state_q;
  logic [CFG_W-1:0]         slots_in_use_q;
  mode_e                    mode_q;
  logic [POS_W-1:0]         pos_q;
  logic [POS_W-1:0]         quo_q;
  logic [BIDX_W-1:0]        rem_q;
  logic [WIDX_W-1:0]        widx_q;
  logic [BASE_W-1:0]        base_q;
  logic                     done_q;
  status_e                  status_q;
  logic [POS_W-1:0]         slot_q;
  logic                     allocated_q;

  logic [WORD_BITS-1:0]     mem_q [WORD_COUNT];
  logic [WORD_COUNT-1:0]    vld_q;
  logic [WORD_BITS-1:0]     rdata_q;
  logic                     rvld_q;

  logic [BASE_W-1:0]        lim;
  logic                     pos_oor;
  logic [PROD_W-1:0]        prod;
  logic [POS_W-1:0]         quo_d;
  logic [WORD_BITS-1:0]     word;
  logic [WIDX_W-1:0]        rd_addr;
  logic                     in_lim;
  logic [BASE_W-1:0]        avail;
  logic [WORD_BITS-1:0]     free_vec;
  logic                     found;
  logic [BIDX_W-1:0]        jsel;
  logic                     last_word;
  logic [BIDX_W-1:0]        bsel;
  logic [WORD_BITS-1:0]     bit_mask;
  logic                     mem_we;
  logic [WIDX_W-1:0]        wr_addr;
  logic [WORD_BITS-1:0]     wr_data;

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign allocated_o = allocated_q;

  // Slot count register; a count above capacity acts as the capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      slots_in_use_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (32'(slots_in_use_q) > 32'(MAX_SLOTS)) begin
      lim = BASE_W'(MAX_SLOTS);
    end else begin
      lim = BASE_W'(slots_in_use_q);
    end
  end

  assign pos_oor = (32'(position_i) >= 32'(lim));

  // Word index of the requested slot, by multiplication with the reciprocal.
  assign prod  = PROD_W'(position_i) * PROD_W'(RECIP);
  assign quo_d = POS_W'(prod >> RSH_W);

  // A word that was never written reads as all free.
  assign word = rvld_q ? rdata_q : '0;

  // Read address: the next word while scanning, the addressed word before a read-modify-write.
  always_comb begin
    unique case (state_q)
      S_DIV: begin
        rd_addr = WIDX_W'(quo_q);
      end
      S_SCAN: begin
        if (widx_q == WIDX_W'(WORD_COUNT - 1)) begin
          rd_addr = '0;
        end else begin
          rd_addr = widx_q + WIDX_W'(1);
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Free slots of the current word that lie below the slot count. Slot 0 of a word is its MSB.
  assign in_lim    = (base_q < lim);
  assign avail     = lim - base_q;
  assign last_word = ((32'(base_q) + WORD_BITS) >= 32'(lim));

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      free_vec[j] = in_lim && !word[WORD_BITS-1-j] && (32'(j) < 32'(avail));
    end
  end

  // Lowest free slot in the word.
  always_comb begin
    found = 1'b0;
    jsel  = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        found = 1'b1;
        jsel  = BIDX_W'(j);
      end
    end
  end

  // Bit select for the read-modify-write and the test result.
  always_comb begin
    if (state_q == S_SCAN) begin
      bsel = BIDX_W'(WORD_BITS - 1) - jsel;
    end else begin
      bsel = BIDX_W'(WORD_BITS - 1) - rem_q;
    end
  end

  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bsel;

  // Write back: set the granted bit, or clear the freed one. Writes happen only in the
  // last cycle of a request, so no later read can overlap a pending write.
  assign mem_we  = ((state_q == S_RMW) && (mode_q == MODE_FREE)) ||
                   ((state_q == S_SCAN) && found);
  assign wr_addr = (state_q == S_SCAN) ? widx_q : WIDX_W'(quo_q);
  assign wr_data = (state_q == S_SCAN) ? (word | bit_mask) : (word & ~bit_mask);

  // Bitmap memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Per-word valid bits, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rvld_q <= vld_q[rd_addr];
    end
  end

  // Request sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_ALLOC;
      pos_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      widx_q      <= '0;
      base_q      <= '0;
      done_q      <= 1'b0;
      status_q    <= STATUS_OK;
      slot_q      <= '0;
      allocated_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            mode_q <= mode_e'(mode_i);
            pos_q  <= position_i;
            quo_q  <= quo_d;
            unique case (mode_e'(mode_i))
              MODE_ALLOC: begin
                widx_q  <= '0;
                base_q  <= '0;
                state_q <= S_SCAN;
              end
              MODE_FREE, MODE_TEST: begin
                if (pos_oor) begin
                  done_q      <= 1'b1;
                  status_q    <= STATUS_RANGE;
                  slot_q      <= position_i;
                  allocated_q <= 1'b0;
                end else begin
                  state_q <= S_DIV;
                end
              end
              MODE_NONE: begin
                done_q      <= 1'b1;
                status_q    <= STATUS_OK;
                slot_q      <= position_i;
                allocated_q <= 1'b0;
              end
            endcase
          end
        end
        S_DIV: begin
          rem_q   <= BIDX_W'(pos_q - POS_W'(32'(quo_q) * WORD_BITS));
          state_q <= S_RMW;
        end
        S_RMW: begin
          done_q      <= 1'b1;
          status_q    <= STATUS_OK;
          slot_q      <= pos_q;
          allocated_q <= (mode_q == MODE_TEST) && word[bsel];
          state_q     <= S_IDLE;
        end
        S_SCAN: begin
          priority if (found) begin
            done_q      <= 1'b1;
            status_q    <= STATUS_OK;
            slot_q      <= POS_W'(32'(base_q) + 32'(jsel));
            allocated_q <= 1'b0;
            state_q     <= S_IDLE;
          end else if (!in_lim || last_word) begin
            done_q      <= 1'b1;
            status_q    <= STATUS_FULL;
            slot_q      <= '0;
            allocated_q <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            widx_q <= widx_q + WIDX_W'(1);
            base_q <= BASE_W'(32'(base_q) + WORD_BITS);
          end
        end
      endcase
    end
  end

  // A result only follows an accepted request or a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without a pending request");

  // Every bitmap write finishes its request in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (done_o && !busy))
    else $error("bitmap write not followed by a result");

  // Only an allocate can report a full bitmap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FULL)) |-> (mode_q == MODE_ALLOC))
    else $error("full status on a non-allocate request");

  // A set test flag comes only from an in-range test.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && allocated_o) |-> ((mode_q == MODE_TEST) && (status_o == STATUS_OK)))
    else $error("allocated flag outside an in-range test");

endmodule
